@@ src/hpe_pkg.sv @@
// hpe_pkg: shared types and constants for the Horner polynomial evaluator.
// Holds word widths, saturation bounds and the per-stage control struct.
// No dependencies.
`default_nettype none

package hpe_pkg;

    localparam int WORD_W         = 32;
    localparam int PROD_W         = 2 * WORD_W;
    localparam int SUM_W          = PROD_W + 1;
    localparam int REG_COUNT      = 8;
    localparam int REG_SEL_W      = $clog2(REG_COUNT);
    localparam int REG_IDX_W      = REG_SEL_W + 1;
    localparam int NUM_COEFFS_DEF = 8;
    localparam int FRAC_BITS_DEF  = 16;

    typedef logic signed [WORD_W-1:0] word_t;
    typedef logic signed [PROD_W-1:0] prod_t;
    typedef logic signed [SUM_W-1:0]  sum_t;
    typedef logic [REG_IDX_W-1:0]     reg_idx_t;

    localparam word_t WORD_MAX = {1'b0, {(WORD_W-1){1'b1}}};
    localparam word_t WORD_MIN = {1'b1, {(WORD_W-1){1'b0}}};

    typedef struct packed {
        logic valid;
        logic sat;
    } stage_ctrl_t;

endpackage

`default_nettype wire

@@ src/hpe_mul.sv @@
// hpe_mul: multiply half of one Horner step, acc * x registered at full width.
// Depends on hpe_pkg.
`default_nettype none

module hpe_mul (
    input  wire                 clk,
    input  wire                 rst_n,
    input  hpe_pkg::stage_ctrl_t ctrl_in,
    input  hpe_pkg::word_t      acc_in,
    input  hpe_pkg::word_t      x_in,
    output hpe_pkg::stage_ctrl_t ctrl_out,
    output hpe_pkg::prod_t      prod_out,
    output hpe_pkg::word_t      x_out
);
    import hpe_pkg::*;

    stage_ctrl_t ctrl_reg;
    prod_t       prod_reg;
    word_t       x_reg;
    prod_t       prod_next;

    assign prod_next = PROD_W'(acc_in) * PROD_W'(x_in);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_reg <= '0;
        end
        else
        begin
            ctrl_reg <= ctrl_in;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        x_reg    <= x_in;
    end

    assign ctrl_out = ctrl_reg;
    assign prod_out = prod_reg;
    assign x_out    = x_reg;

endmodule

`default_nettype wire

@@ src/hpe_add.sv @@
// hpe_add: add half of one Horner step, floor shift, coefficient add, 32-bit clip.
// Depends on hpe_pkg.
`default_nettype none

module hpe_add #(
    parameter int FRAC_BITS = hpe_pkg::FRAC_BITS_DEF
) (
    input  wire                 clk,
    input  wire                 rst_n,
    input  hpe_pkg::stage_ctrl_t ctrl_in,
    input  hpe_pkg::prod_t      prod_in,
    input  hpe_pkg::word_t      x_in,
    input  hpe_pkg::word_t      coeff,
    output hpe_pkg::stage_ctrl_t ctrl_out,
    output hpe_pkg::word_t      acc_out,
    output hpe_pkg::word_t      x_out
);
    import hpe_pkg::*;

    stage_ctrl_t ctrl_reg;
    word_t       acc_reg;
    word_t       x_reg;
    stage_ctrl_t ctrl_next;
    word_t       acc_next;
    prod_t       shifted;
    sum_t        sum;
    logic [SUM_W-WORD_W:0] sum_hi;
    logic        in_range;

    assign shifted  = prod_in >>> FRAC_BITS;
    assign sum      = {shifted[PROD_W-1], shifted}
                    + {{(SUM_W-WORD_W){coeff[WORD_W-1]}}, coeff};
    assign sum_hi   = sum[SUM_W-1:WORD_W-1];
    assign in_range = (&sum_hi) | ~(|sum_hi);

    always_comb
    begin
        ctrl_next.valid = ctrl_in.valid;
        ctrl_next.sat   = ctrl_in.sat | ~in_range;
        if (in_range)
        begin
            acc_next = sum[WORD_W-1:0];
        end
        else
        begin
            acc_next = sum[SUM_W-1] ? WORD_MIN : WORD_MAX;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_reg <= '0;
        end
        else
        begin
            ctrl_reg <= ctrl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        x_reg   <= x_in;
    end

    assign ctrl_out = ctrl_reg;
    assign acc_out  = acc_reg;
    assign x_out    = x_reg;

endmodule

`default_nettype wire

@@ src/horner_polynomial_evaluate.sv @@
// horner_polynomial_evaluate: top level, coefficient registers and Horner pipeline.
// Depends on hpe_pkg, hpe_mul and hpe_add.
//
// Usage:
//   Coefficients coeff_0..coeff_7 (signed Q16.16) are written through wr_en,
//   wr_index and wr_data; index 8 and above is ignored. Write only while idle.
//   An x word is taken on any clock edge with start high; busy is always low,
//   so a new word may enter every cycle.
//   Each Horner step is a multiply stage and a shift/add/clip stage; the top
//   coefficient is loaded in one entry stage. Throughput is one word per
//   cycle, set by the one 32x32 multiplier per step.
//   done pulses for one cycle with y_value and saturated; the result cannot
//   be held off, so the pipeline never stalls.
//   Reset clears all coefficients to zero and drops every word in flight.
`default_nettype none

module horner_polynomial_evaluate #(
    parameter int NUM_COEFFS = hpe_pkg::NUM_COEFFS_DEF,
    parameter int FRAC_BITS  = hpe_pkg::FRAC_BITS_DEF
) (
    input  wire               clk,
    input  wire               rst_n,
    input  wire               wr_en,
    input  hpe_pkg::reg_idx_t wr_index,
    input  hpe_pkg::word_t    wr_data,
    input  wire               start,
    output logic              busy,
    input  hpe_pkg::word_t    x_value,
    output logic              done,
    output hpe_pkg::word_t    y_value,
    output logic              saturated
);
    import hpe_pkg::*;

    word_t       coeff_reg [REG_COUNT];
    stage_ctrl_t ctrl0_reg;
    word_t       acc0_reg;
    word_t       x0_reg;

    stage_ctrl_t ctrl_s [NUM_COEFFS];
    word_t       acc_s  [NUM_COEFFS];
    word_t       x_s    [NUM_COEFFS];

    assign busy = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < REG_COUNT; i++)
            begin
                coeff_reg[i] <= '0;
            end
        end
        else if (wr_en && (wr_index < REG_IDX_W'(REG_COUNT)))
        begin
            coeff_reg[wr_index[REG_SEL_W-1:0]] <= wr_data;
        end
    end

    // entry stage: first step reduces to the top coefficient
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl0_reg <= '0;
        end
        else
        begin
            ctrl0_reg.valid <= start & ~busy;
            ctrl0_reg.sat   <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        acc0_reg <= coeff_reg[NUM_COEFFS-1];
        x0_reg   <= x_value;
    end

    assign ctrl_s[0] = ctrl0_reg;
    assign acc_s[0]  = acc0_reg;
    assign x_s[0]    = x0_reg;

    for (genvar k = 1; k < NUM_COEFFS; k++)
    begin : g_step
        stage_ctrl_t mul_ctrl;
        prod_t       mul_prod;
        word_t       mul_x;

        hpe_mul u_mul (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctrl_in  (ctrl_s[k-1]),
            .acc_in   (acc_s[k-1]),
            .x_in     (x_s[k-1]),
            .ctrl_out (mul_ctrl),
            .prod_out (mul_prod),
            .x_out    (mul_x)
        );

        hpe_add #(
            .FRAC_BITS (FRAC_BITS)
        ) u_add (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctrl_in  (mul_ctrl),
            .prod_in  (mul_prod),
            .x_in     (mul_x),
            .coeff    (coeff_reg[NUM_COEFFS-1-k]),
            .ctrl_out (ctrl_s[k]),
            .acc_out  (acc_s[k]),
            .x_out    (x_s[k])
        );
    end

    assign done      = ctrl_s[NUM_COEFFS-1].valid;
    assign saturated = ctrl_s[NUM_COEFFS-1].sat;
    assign y_value   = acc_s[NUM_COEFFS-1];

endmodule

`default_nettype wire
